/* rtl/core/ffp_pkg.sv */
`timescale 1ns / 1ps

package ffp_pkg;

	// framing constants
	localparam int FRAGMENT_PAYLOAD = 1352;
	localparam int MAX_DIMENSION    = 1024;
	localparam int HEADER_BYTES     = 48;

	// field widths
	localparam int BYTE_W    = 8;
	localparam int DIM_W     = 11;
	localparam int SEQ_W     = 32;
	localparam int TIME_W    = 64;
	localparam int SESSION_W = 64;
	localparam int COUNT_W   = 12;

	// derived widths
	localparam int MAX_TOTAL  = MAX_DIMENSION * MAX_DIMENSION * 4;
	localparam int TOTAL_W    = $clog2(MAX_TOTAL + 1);
	localparam int NUM_W      = $clog2(MAX_TOTAL + FRAGMENT_PAYLOAD);
	localparam int FILL_W     = $clog2(FRAGMENT_PAYLOAD + 1);
	localparam int PROD_W     = 2 * DIM_W;
	localparam int HDR_CNT_W  = $clog2(HEADER_BYTES + 1);
	localparam int HDR_IDX_W  = $clog2(HEADER_BYTES);

	// reciprocal of the fragment size, exact floor for any NUM_W-bit numerator
	localparam int RECIP_SHIFT = NUM_W + $clog2(FRAGMENT_PAYLOAD);
	localparam longint unsigned RECIP_MUL = ((64'd1 << RECIP_SHIFT) +
		64'(FRAGMENT_PAYLOAD - 1)) / 64'(FRAGMENT_PAYLOAD);
	localparam int RECIP_W     = $clog2(RECIP_MUL + 1);
	localparam int QUOT_W      = NUM_W + RECIP_W;

	// fixed header codes
	localparam logic [31:0] HDR_TAG     = 32'h5556_4631;
	localparam logic [7:0]  HDR_VERSION = 8'd1;
	localparam logic [7:0]  HDR_FORMAT  = 8'd2;

	// one classified request between front and back
	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic               hdr;
		logic               eod;
		logic               eof;
		logic [SEQ_W-1:0]   seq;
		logic [TIME_W-1:0]  ctime;
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [TOTAL_W-1:0] total;
		logic [COUNT_W-1:0] index;
		logic [COUNT_W-1:0] count;
		logic [TOTAL_W-1:0] offset;
	} ffp_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ffp_queue_status_t;

	typedef enum logic [1:0] {
		FS_RUN,
		FS_MUL,
		FS_DIV,
		FS_PUSH
	} ffp_front_state_t;

	typedef logic [0:HEADER_BYTES-1][7:0] ffp_header_t;

	// big-endian header, first byte at index 0
	function automatic ffp_header_t build_header(input logic [SESSION_W-1:0] session,
		input ffp_item_t it);
		build_header = {HDR_TAG, HDR_VERSION, HDR_FORMAT, 16'(HEADER_BYTES), session,
			it.seq, it.ctime, 16'(it.width), 16'(it.height), 32'(it.total),
			16'(it.index), 16'(it.count), 32'(it.offset), 16'(FRAGMENT_PAYLOAD),
			16'h0000};
	endfunction

endpackage

/* rtl/core/ffp_front.sv */
`timescale 1ns / 1ps

module ffp_front import ffp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [BYTE_W-1:0]   pixel_byte,
	input  logic [SEQ_W-1:0]    seq_number,
	input  logic [TIME_W-1:0]   capture_time,
	input  logic [DIM_W-1:0]    frame_width,
	input  logic [DIM_W-1:0]    frame_height,
	input  ffp_queue_status_t   qstat,
	output logic                push,
	output ffp_item_t           push_item
);

	// zero goes to one, oversize goes to the maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			clamp_dim = DIM_W'(1);
		end else if (32'(v) > MAX_DIMENSION) begin
			clamp_dim = DIM_W'(MAX_DIMENSION);
		end else begin
			clamp_dim = v;
		end
	endfunction

	ffp_front_state_t    state_q, state_next;
	logic [TOTAL_W-1:0]  pos_q;
	logic [FILL_W-1:0]   fill_q;
	logic [COUNT_W-1:0]  idx_q;
	logic [TOTAL_W-1:0]  off_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [COUNT_W-1:0]  count_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [TIME_W-1:0]   time_q;
	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;
	logic [BYTE_W-1:0]   pend_byte_q;
	logic [NUM_W-1:0]    num_q;

	logic                accept;
	logic                start;
	logic [TOTAL_W-1:0]  new_pos;
	logic [FILL_W-1:0]   new_fill;
	logic                last_frame;
	logic                last_dgram;
	logic [PROD_W-1:0]   prod;
	logic [TOTAL_W-1:0]  total_next;
	logic [QUOT_W-1:0]   quot;
	logic [COUNT_W-1:0]  count_next;

	// input handshake and classification
	assign in_stall = (state_q != FS_RUN) || qstat.full;
	assign accept   = in_valid && !in_stall;
	assign start    = accept && (pos_q == '0);
	assign push     = (accept && (pos_q != '0)) || ((state_q == FS_PUSH) && !qstat.full);

	// frame counters seen by the byte being pushed
	assign new_pos    = pos_q + 1'b1;
	assign new_fill   = fill_q + 1'b1;
	assign last_frame = new_pos >= total_q;
	assign last_dgram = last_frame || (new_fill >= FILL_W'(FRAGMENT_PAYLOAD));

	always_comb begin
		push_item.data   = (state_q == FS_PUSH) ? pend_byte_q : pixel_byte;
		push_item.hdr    = (fill_q == '0);
		push_item.eod    = last_dgram;
		push_item.eof    = last_frame;
		push_item.seq    = seq_q;
		push_item.ctime  = time_q;
		push_item.width  = width_q;
		push_item.height = height_q;
		push_item.total  = total_q;
		push_item.index  = idx_q;
		push_item.count  = count_q;
		push_item.offset = off_q;
	end

	// frame size, then fragment count as a reciprocal multiply of total plus payload-1
	assign prod       = width_q * height_q;
	assign total_next = TOTAL_W'({prod, 2'b00});
	assign quot       = num_q * RECIP_W'(RECIP_MUL);
	assign count_next = COUNT_W'(quot >> RECIP_SHIFT);

	// sequencer for the start of a frame
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			FS_RUN:  if (start) state_next = FS_MUL;
			FS_MUL:  state_next = FS_DIV;
			FS_DIV:  state_next = FS_PUSH;
			FS_PUSH: if (!qstat.full) state_next = FS_RUN;
			default: state_next = FS_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_RUN;
		end else begin
			state_q <= state_next;
		end
	end

	// frame state, latched fields and fragment count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			fill_q   <= '0;
			idx_q    <= '0;
			off_q    <= '0;
			total_q  <= '0;
			count_q  <= '0;
			seq_q    <= '0;
			time_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			num_q    <= '0;
		end else begin
			if (start) begin
				seq_q    <= seq_number;
				time_q   <= capture_time;
				width_q  <= clamp_dim(frame_width);
				height_q <= clamp_dim(frame_height);
			end
			if (state_q == FS_MUL) begin
				total_q <= total_next;
				num_q   <= NUM_W'(total_next) + NUM_W'(FRAGMENT_PAYLOAD - 1);
			end
			if (state_q == FS_DIV) begin
				count_q <= count_next;
			end
			if (push) begin
				if (last_frame) begin
					pos_q  <= '0;
					fill_q <= '0;
					idx_q  <= '0;
					off_q  <= '0;
				end else if (last_dgram) begin
					pos_q  <= new_pos;
					fill_q <= '0;
					idx_q  <= idx_q + 1'b1;
					off_q  <= off_q + TOTAL_W'(FRAGMENT_PAYLOAD);
				end else begin
					pos_q  <= new_pos;
					fill_q <= new_fill;
				end
			end
		end
	end

	// first byte of a frame waits here during the count
	always_ff @(posedge clk) begin
		if (start) begin
			pend_byte_q <= pixel_byte;
		end
	end

endmodule

/* rtl/core/ffp_queue.sv */
`timescale 1ns / 1ps

module ffp_queue import ffp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ffp_item_t         push_item,
	input  logic              pop,
	output ffp_item_t         head,
	output ffp_queue_status_t status
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	ffp_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = (cnt_q == CNT_W'(DEPTH));
	assign status.empty = (cnt_q == '0);

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* rtl/core/ffp_back.sv */
`timescale 1ns / 1ps

module ffp_back import ffp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [SESSION_W-1:0] session,
	input  ffp_item_t            head,
	input  ffp_queue_status_t    qstat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 is_payload,
	output logic                 end_of_datagram,
	output logic                 end_of_frame
);

	logic [HDR_CNT_W-1:0] hcnt_q;
	logic                 out_valid_q;
	logic [BYTE_W-1:0]    out_byte_q;
	logic                 is_payload_q;
	logic                 eod_q;
	logic                 eof_q;

	logic                 load;
	logic                 in_header;
	ffp_header_t          header_vec;
	logic [BYTE_W-1:0]    hdr_byte;

	// one output byte per cycle while the output register has room
	assign load       = !qstat.empty && (!out_valid_q || !out_stall);
	assign in_header  = head.hdr && (hcnt_q != HDR_CNT_W'(HEADER_BYTES));
	assign header_vec = build_header(session, head);
	assign hdr_byte   = in_header ? header_vec[hcnt_q[HDR_IDX_W-1:0]] : '0;
	assign pop        = load && !in_header;

	// header byte counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				hcnt_q      <= in_header ? (hcnt_q + 1'b1) : '0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= in_header ? hdr_byte : head.data;
			is_payload_q <= !in_header;
			eod_q        <= !in_header && head.eod;
			eof_q        <= !in_header && head.eof;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_byte        = out_byte_q;
	assign is_payload      = is_payload_q;
	assign end_of_datagram = eod_q;
	assign end_of_frame    = eof_q;

endmodule

/* rtl/core/frame_fragment_packetizer_core.sv */
`timescale 1ns / 1ps

// Frame fragment packetizer: raw BGRA bytes go in one per request and come out
// as a byte stream of datagrams, each a 48-byte big-endian header followed by
// up to 1352 payload bytes; is_payload marks the pixel bytes, end_of_datagram
// and end_of_frame mark the last payload byte of a fragment and of the frame.
// The output side moves one byte per cycle while out_stall is low, and every
// fragment start adds 48 header bytes ahead of its payload. The first byte of
// each frame holds the input while the front forms the width times height
// product, then the fragment count by reciprocal multiplication, then hands
// the byte to the queue; other bytes are taken every cycle while the
// two-entry queue in front of the output has room.
// The session id register resets to 1 and is written through the cfg channel,
// which is always ready; write it only while no frame bytes are in flight.
module frame_fragment_packetizer_core import ffp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [SESSION_W-1:0] session_id,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    pixel_byte,
	input  logic [SEQ_W-1:0]     seq_number,
	input  logic [TIME_W-1:0]    capture_time,
	input  logic [DIM_W-1:0]     frame_width,
	input  logic [DIM_W-1:0]     frame_height,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 is_payload,
	output logic                 end_of_datagram,
	output logic                 end_of_frame
);

	logic [SESSION_W-1:0] session_q;
	logic                 q_push;
	logic                 q_pop;
	ffp_item_t            q_push_item;
	ffp_item_t            q_head;
	ffp_queue_status_t    q_status;

	// session id register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_q <= SESSION_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			session_q <= session_id;
		end
	end

	// classification and frame counters
	ffp_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel_byte     (pixel_byte),
		.seq_number     (seq_number),
		.capture_time   (capture_time),
		.frame_width    (frame_width),
		.frame_height   (frame_height),
		.qstat          (q_status),
		.push           (q_push),
		.push_item      (q_push_item)
	);

	// decoupling queue
	ffp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.pop       (q_pop),
		.head      (q_head),
		.status    (q_status)
	);

	// header and payload serializer
	ffp_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.session         (session_q),
		.head            (q_head),
		.qstat           (q_status),
		.pop             (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.is_payload      (is_payload),
		.end_of_datagram (end_of_datagram),
		.end_of_frame    (end_of_frame)
	);

	// checks
	a_flags_only_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (end_of_datagram || end_of_frame) |-> is_payload)
		else $error("end flag on a header byte");

	a_frame_end_ends_datagram: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> end_of_datagram)
		else $error("frame end without datagram end");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_status.full))
		else $error("queue push while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_status.empty))
		else $error("queue pop while empty");

endmodule

/* tb/frame_fragment_packetizer_core_test.sv */
`timescale 1ns / 1ps

module frame_fragment_packetizer_core_test;
	import ffp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned SETTLE_CYCLES = 30;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned PHASE_BYTES = 90;

	// one pixel request as driven on the input ports
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic [SEQ_W-1:0]  seq;
		logic [TIME_W-1:0] stamp;
		logic [DIM_W-1:0]  width;
		logic [DIM_W-1:0]  height;
	} pixel_req_t;

	// one byte of the datagram stream
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              payload;
		logic              eod;
		logic              eof;
	} stream_byte_t;

	// directed row: request plus the payload flags it must carry
	typedef struct packed {
		pixel_req_t req;
		logic       eod;
		logic       eof;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [SESSION_W-1:0] session_id = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [BYTE_W-1:0]    pixel_byte = '0;
	logic [SEQ_W-1:0]     seq_number = '0;
	logic [TIME_W-1:0]    capture_time = '0;
	logic [DIM_W-1:0]     frame_width = '0;
	logic [DIM_W-1:0]     frame_height = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [BYTE_W-1:0]    out_byte;
	logic                 is_payload;
	logic                 end_of_datagram;
	logic                 end_of_frame;

	frame_fragment_packetizer_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.session_id      (session_id),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pixel_byte      (pixel_byte),
		.seq_number      (seq_number),
		.capture_time    (capture_time),
		.frame_width     (frame_width),
		.frame_height    (frame_height),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_byte        (out_byte),
		.is_payload      (is_payload),
		.end_of_datagram (end_of_datagram),
		.end_of_frame    (end_of_frame)
	);

	always #1 clk = ~clk;

	// packetizer shadow state
	logic [SESSION_W-1:0] session_reg = 64'd1;
	logic [22:0]          byte_pos = '0;
	logic [COUNT_W-1:0]   frag_index = '0;
	logic [22:0]          frag_offset = '0;
	logic [10:0]          frag_fill = '0;
	logic [COUNT_W-1:0]   frag_count = '0;
	logic [22:0]          frame_total = '0;
	logic [SEQ_W-1:0]     seq_hold = '0;
	logic [TIME_W-1:0]    time_hold = '0;
	logic [DIM_W-1:0]     width_hold = '0;
	logic [DIM_W-1:0]     height_hold = '0;

	stream_byte_t step_bytes [0:HEADER_BYTES];
	int unsigned  step_count;
	stream_byte_t pending_bytes [$];
	int unsigned  mismatches = 0;
	int unsigned  cycles = 0;
	bit           no_idle = 1'b0;

	// four short frames: 1x1 after reset, 0x0 clamped, 2x1, 1x2
	dir_row_t dir_rows [24] = '{
		'{'{8'h00, 32'h0000_0000, 64'h0, 11'd1, 11'd1}, 1'b0, 1'b0},
		'{'{8'hFF, 32'h0000_0000, 64'h0, 11'd0, 11'd0}, 1'b0, 1'b0},
		'{'{8'h80, 32'h0000_0000, 64'h0, 11'd0, 11'd0}, 1'b0, 1'b0},
		'{'{8'h7F, 32'h0000_0000, 64'h0, 11'd0, 11'd0}, 1'b1, 1'b1},
		'{'{8'h01, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 11'd0, 11'd0}, 1'b0, 1'b0},
		'{'{8'hFE, 32'h0000_0000, 64'h0, 11'd0, 11'd0}, 1'b0, 1'b0},
		'{'{8'h55, 32'h0000_0000, 64'h0, 11'd0, 11'd0}, 1'b0, 1'b0},
		'{'{8'hAA, 32'h0000_0000, 64'h0, 11'd0, 11'd0}, 1'b1, 1'b1},
		'{'{8'h10, 32'h8000_0001, 64'h8000_0000_0000_0001, 11'd2, 11'd1}, 1'b0, 1'b0},
		'{'{8'h11, 32'h0000_0000, 64'h0, 11'd0, 11'd0}, 1'b0, 1'b0},
		'{'{8'h12, 32'h0000_0000, 64'h0, 11'd0, 11'd0}, 1'b0, 1'b0},
		'{'{8'h13, 32'h0000_0000, 64'h0, 11'd0, 11'd0}, 1'b0, 1'b0},
		'{'{8'h14, 32'h0000_0000, 64'h0, 11'd0, 11'd0}, 1'b0, 1'b0},
		'{'{8'h15, 32'h0000_0000, 64'h0, 11'd0, 11'd0}, 1'b0, 1'b0},
		'{'{8'h16, 32'h0000_0000, 64'h0, 11'd0, 11'd0}, 1'b0, 1'b0},
		'{'{8'h17, 32'h0000_0000, 64'h0, 11'd0, 11'd0}, 1'b1, 1'b1},
		'{'{8'hC0, 32'h1234_5678, 64'h0123_4567_89AB_CDEF, 11'd1, 11'd2}, 1'b0, 1'b0},
		'{'{8'hC1, 32'h0000_0000, 64'h0, 11'h7FF, 11'h7FF}, 1'b0, 1'b0},
		'{'{8'hC2, 32'h0000_0000, 64'h0, 11'h7FF, 11'h7FF}, 1'b0, 1'b0},
		'{'{8'hC3, 32'h0000_0000, 64'h0, 11'h7FF, 11'h7FF}, 1'b0, 1'b0},
		'{'{8'hC4, 32'h0000_0000, 64'h0, 11'h7FF, 11'h7FF}, 1'b0, 1'b0},
		'{'{8'hC5, 32'h0000_0000, 64'h0, 11'h7FF, 11'h7FF}, 1'b0, 1'b0},
		'{'{8'hC6, 32'h0000_0000, 64'h0, 11'h7FF, 11'h7FF}, 1'b0, 1'b0},
		'{'{8'hC7, 32'h0000_0000, 64'h0, 11'h7FF, 11'h7FF}, 1'b1, 1'b1}
	};

	function automatic logic [DIM_W-1:0] clamp_dimension(input logic [DIM_W-1:0] v);
		if (v == '0)
			return DIM_W'(1);
		if (v > MAX_DIMENSION)
			return DIM_W'(MAX_DIMENSION);
		return v;
	endfunction

	function automatic int unsigned pause_len();
		return no_idle ? 0 : $urandom_range(0, 8);
	endfunction

	// stream bytes caused by one accepted pixel request
	function automatic void packetize_byte(input pixel_req_t r);
		logic [HEADER_BYTES*8-1:0] hdr;
		logic last_frame;
		logic last_dgram;
		step_count = 0;
		// frame fields latch on the first byte
		if (byte_pos == '0) begin
			seq_hold = r.seq;
			time_hold = r.stamp;
			width_hold = clamp_dimension(r.width);
			height_hold = clamp_dimension(r.height);
			frame_total = 23'(32'(width_hold) * 32'(height_hold) * 4);
			frag_count = COUNT_W'((32'(frame_total) + FRAGMENT_PAYLOAD - 1) / FRAGMENT_PAYLOAD);
			frag_index = '0;
			frag_offset = '0;
			frag_fill = '0;
		end
		// big-endian header ahead of each fragment
		if (frag_fill == '0) begin
			hdr = {HDR_TAG, HDR_VERSION, HDR_FORMAT, 16'(HEADER_BYTES), session_reg,
				seq_hold, time_hold, 16'(width_hold), 16'(height_hold), 32'(frame_total),
				16'(frag_index), 16'(frag_count), 32'(frag_offset), 16'(FRAGMENT_PAYLOAD),
				16'h0000};
			for (int k = 0; k < HEADER_BYTES; k++)
				step_bytes[k] = '{hdr[HEADER_BYTES*8-1-8*k -: 8], 1'b0, 1'b0, 1'b0};
			step_count = HEADER_BYTES;
		end
		byte_pos = byte_pos + 1'b1;
		frag_fill = frag_fill + 1'b1;
		last_frame = byte_pos >= frame_total;
		last_dgram = last_frame || frag_fill >= FRAGMENT_PAYLOAD;
		step_bytes[step_count] = '{r.data, 1'b1, last_dgram, last_frame};
		step_count++;
		// counters advance or restart
		if (last_frame) begin
			byte_pos = '0;
			frag_index = '0;
			frag_offset = '0;
			frag_fill = '0;
		end else if (last_dgram) begin
			frag_fill = '0;
			frag_index = frag_index + 1'b1;
			frag_offset = 23'(frag_offset + FRAGMENT_PAYLOAD);
		end
	endfunction

	task automatic report_mismatch(input string what, input stream_byte_t want,
		input stream_byte_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t %s: expected %h/%b/%b/%b, got %h/%b/%b/%b",
				$realtime, what, want.data, want.payload, want.eod, want.eof,
				got.data, got.payload, got.eod, got.eof);
	endtask

	// send one pixel request; typed rows carry their own payload flags
	task automatic push_pixel(input pixel_req_t r, input bit typed, input logic eod,
		input logic eof);
		int unsigned gap;
		gap = pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_byte <= r.data;
		seq_number <= r.seq;
		capture_time <= r.stamp;
		frame_width <= r.width;
		frame_height <= r.height;
		do @(posedge clk); while (in_stall);
		packetize_byte(r);
		for (int k = 0; k < step_count - 1; k++)
			pending_bytes.insert(pending_bytes.size(), step_bytes[k]);
		if (typed)
			pending_bytes.insert(pending_bytes.size(),
				stream_byte_t'{r.data, 1'b1, eod, eof});
		else
			pending_bytes.insert(pending_bytes.size(), step_bytes[step_count-1]);
	endtask

	// hold off input until every expected byte has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_bytes.size() != 0);
	endtask

	task automatic write_session(input logic [SESSION_W-1:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		session_id <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		session_reg = v;
	endtask

	// frame of random pixels cut after byte_cap bytes; later bytes carry noise
	// in the frame fields
	task automatic drive_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
		input int drain_at, input int byte_cap);
		int total;
		pixel_req_t r;
		total = 4 * int'(clamp_dimension(w)) * int'(clamp_dimension(h));
		if (total > byte_cap)
			total = byte_cap;
		for (int i = 0; i < total; i++) begin
			if (i % 256 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (i == drain_at)
				wait_drained();
			r.data = BYTE_W'($urandom);
			r.seq = $urandom;
			r.stamp = {$urandom, $urandom};
			r.width = (i == 0) ? w : DIM_W'($urandom);
			r.height = (i == 0) ? h : DIM_W'($urandom);
			push_pixel(r, 1'b0, 1'b0, 1'b0);
		end
	endtask

	// output side raises out_stall for a random pause ahead of each output byte
	initial begin
		int unsigned n;
		forever begin
			n = pause_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare each accepted output byte with the oldest expectation
	always @(posedge clk) begin
		stream_byte_t got;
		stream_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_byte, is_payload, end_of_datagram, end_of_frame};
			if (pending_bytes.size() == 0) begin
				report_mismatch("byte with nothing expected", '0, got);
			end else begin
				want = pending_bytes.pop_front();
				if (got !== want)
					report_mismatch("stream mismatch", want, got);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int unsigned sent;
		logic [SESSION_W-1:0] phase_session [4];
		logic [DIM_W-1:0] fw;
		logic [DIM_W-1:0] fh;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames, session from reset then all ones
		foreach (dir_rows[i]) begin
			if (i == 8)
				write_session('1);
			push_pixel(dir_rows[i].req, 1'b1, dir_rows[i].eod, dir_rows[i].eof);
		end

		// random small frames over several session values
		phase_session[0] = 64'd1;
		phase_session[1] = {$urandom, $urandom} | 64'd1;
		phase_session[2] = 64'h8000_0000_0000_0000;
		phase_session[3] = {$urandom, $urandom} | 64'd1;
		for (int p = 0; p < 4; p++) begin
			write_session(phase_session[p]);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				fw = DIM_W'($urandom_range(0, 4));
				fh = DIM_W'($urandom_range(0, 4));
				drive_frame(fw, fh, -1, 256);
				sent += 4 * int'(clamp_dimension(fw)) * int'(clamp_dimension(fh));
			end
		end

		// oversize frame clamps to 1024 by 1024; only its opening bytes are sent
		write_session({$urandom, $urandom} | 64'd1);
		drive_frame(11'h7FF, 11'h7FF, 30, 60);

		wait_drained();
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (mismatches == 0 && pending_bytes.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
